FILE: design/rbc_pkg.sv
`default_nettype none

package rbc_pkg;

  localparam int unsigned MAX_BYTES = 65536;
  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned WPTR_W    = 18;
  localparam int unsigned RPTR_W    = 17;
  localparam int unsigned MPTR_W    = 18;
  localparam int unsigned OFF_W     = 16;
  localparam int unsigned ROOM_W    = 17;
  localparam int unsigned AMT_W     = 17;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 17;
  // Signed width for the difference of any two pointers or sizes.
  localparam int unsigned CALC_W    = 20;

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_BYTES);

  typedef enum logic [ACT_W-1:0] {
    ACT_QUERY  = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_MIDDLE = 3'd2,
    ACT_POP    = 3'd3,
    ACT_RESET  = 3'd4
  } rbc_action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_OVER = 2'd2
  } rbc_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_SIZE = 2'd0,
    CFG_MIDDLE_ON   = 2'd1
  } rbc_cfg_e;

  typedef struct packed {
    logic [OFF_W-1:0]  write_offset;
    logic [ROOM_W-1:0] write_room;
    logic [OFF_W-1:0]  middle_offset;
    logic [ROOM_W-1:0] middle_room;
    logic [OFF_W-1:0]  read_offset;
    logic [ROOM_W-1:0] read_room;
    logic [ROOM_W-1:0] fill_length;
  } rbc_view_t;

  typedef struct packed {
    rbc_status_e status;
    rbc_view_t   view;
  } rbc_result_t;

  // Difference a - b clipped at zero and cut to the room width.
  function automatic logic [ROOM_W-1:0] room_diff(logic signed [CALC_W-1:0] a,
                                                  logic signed [CALC_W-1:0] b);
    logic signed [CALC_W-1:0] d;
    d = a - b;
    return d[CALC_W-1] ? '0 : d[ROOM_W-1:0];
  endfunction

  // Ring offset of an unwrapped pointer.
  function automatic logic [OFF_W-1:0] ring_offset(logic [MPTR_W-1:0] p,
                                                   logic [SIZE_W-1:0] s);
    logic [MPTR_W-1:0] o;
    o = (p >= MPTR_W'(s)) ? (p - MPTR_W'(s)) : p;
    return o[OFF_W-1:0];
  endfunction

  // Pointer lowered by the ring size, stopping at zero.
  function automatic logic [MPTR_W-1:0] drop_size(logic [MPTR_W-1:0] p,
                                                  logic [SIZE_W-1:0] s);
    return (p >= MPTR_W'(s)) ? (p - MPTR_W'(s)) : '0;
  endfunction

  function automatic rbc_view_t make_view(logic [WPTR_W-1:0] w,
                                          logic [RPTR_W-1:0] r,
                                          logic [MPTR_W-1:0] m,
                                          logic [SIZE_W-1:0] s,
                                          logic              on);
    rbc_view_t v;
    logic signed [CALC_W-1:0] ws, rs, ms, ss, lim;
    ws = CALC_W'(w);
    rs = CALC_W'(r);
    ms = CALC_W'(m);
    ss = CALC_W'(s);
    lim = on ? ms : ws;
    v.write_offset  = ring_offset(MPTR_W'(w), s);
    v.write_room    = (ws >= ss) ? room_diff(ss + rs, ws) : room_diff(ss, ws);
    v.middle_offset = on ? ring_offset(m, s) : '0;
    if (!on) begin
      v.middle_room = '0;
    end else if (ms < ss && ws > ss) begin
      v.middle_room = room_diff(ss, ms);
    end else begin
      v.middle_room = room_diff(ws, ms);
    end
    v.read_offset   = r[OFF_W-1:0];
    v.read_room     = (lim > ss) ? room_diff(ss, rs) : room_diff(lim, rs);
    v.fill_length   = room_diff(ws, rs);
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/three_pointer_ring_buffer_control_top.sv
// Pointer controller for a byte ring buffer with write, middle and read pointers.
// Input channel (in_valid_i/in_ready_o) carries one command per beat: query,
// commit written, commit processed, pop, or pointer reset, with a byte amount.
// Output channel (out_valid_o/out_ready_i) returns one result beat per command:
// a status plus the offset and contiguous room of each stage and the fill
// length, all taken after the command has been applied.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes buffer_size (index 0)
// or middle_stage_on (index 1); it is always ready. Write it only while no
// command is in flight. Writing middle_stage_on moves the middle pointer to
// the read pointer.
// From input beat to output beat the command first waits in the input register,
// then executes against the pointer registers and its result loads the output
// register. One command is accepted every cycle while the output is not stalled.
// When the receiver stalls, the result holds in the output register, the
// command behind it waits in the input register, and in_ready_o drops only
// once both are occupied.
// Reset clears all pointers, disables the middle stage and sets buffer_size to
// 65536; no output beat is pending after reset.
`default_nettype none

module three_pointer_ring_buffer_control_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rbc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rbc_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rbc_pkg::ACT_W-1:0]     action_i,
  input  wire logic [rbc_pkg::AMT_W-1:0]     amount_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rbc_pkg::STAT_W-1:0]         status_o,
  output logic [rbc_pkg::OFF_W-1:0]          write_offset_o,
  output logic [rbc_pkg::ROOM_W-1:0]         write_room_o,
  output logic [rbc_pkg::OFF_W-1:0]          middle_offset_o,
  output logic [rbc_pkg::ROOM_W-1:0]         middle_room_o,
  output logic [rbc_pkg::OFF_W-1:0]          read_offset_o,
  output logic [rbc_pkg::ROOM_W-1:0]         read_room_o,
  output logic [rbc_pkg::ROOM_W-1:0]         fill_length_o
);
  import rbc_pkg::*;

  logic             in_valid_q, in_valid_d;
  logic [ACT_W-1:0] action_q;
  logic [AMT_W-1:0] amount_q;
  logic             out_can_load;
  logic             exec;
  rbc_result_t      core_result;
  rbc_result_t      out_result;

  assign cfg_ready_o = 1'b1;
  assign exec        = in_valid_q && out_can_load;
  assign in_ready_o  = !in_valid_q || exec;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (exec) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_i;
      amount_q <= amount_i;
    end
  end

  rbc_ptr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .exec_i      (exec),
    .action_i    (action_q),
    .amount_i    (amount_q),
    .result_o    (core_result)
  );

  rbc_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (exec),
    .result_i   (core_result),
    .can_load_o (out_can_load),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .result_o   (out_result)
  );

  assign status_o        = out_result.status;
  assign write_offset_o  = out_result.view.write_offset;
  assign write_room_o    = out_result.view.write_room;
  assign middle_offset_o = out_result.view.middle_offset;
  assign middle_room_o   = out_result.view.middle_room;
  assign read_offset_o   = out_result.view.read_offset;
  assign read_room_o     = out_result.view.read_room;
  assign fill_length_o   = out_result.view.fill_length;

endmodule

`default_nettype wire

FILE: design/rbc_ptr_core.sv
`default_nettype none

module rbc_ptr_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [rbc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rbc_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  wire logic                         exec_i,
  input  wire logic [rbc_pkg::ACT_W-1:0]    action_i,
  input  wire logic [rbc_pkg::AMT_W-1:0]    amount_i,
  output rbc_pkg::rbc_result_t              result_o
);
  import rbc_pkg::*;

  logic [SIZE_W-1:0] buffer_size_q, buffer_size_d;
  logic              middle_on_q, middle_on_d;
  logic [WPTR_W-1:0] wp_q, wp_d;
  logic [RPTR_W-1:0] rp_q, rp_d;
  logic [MPTR_W-1:0] mp_q, mp_d;

  logic [SIZE_W-1:0] size_eff;
  rbc_view_t         cur_view;
  logic [ROOM_W-1:0] room;
  rbc_status_e       status;
  logic [RPTR_W:0]   rd_sum;

  always_comb begin
    if (buffer_size_q == '0) begin
      size_eff = SIZE_W'(1);
    end else if (buffer_size_q > MAX_SIZE) begin
      size_eff = MAX_SIZE;
    end else begin
      size_eff = buffer_size_q;
    end
  end

  assign cur_view = make_view(wp_q, rp_q, mp_q, size_eff, middle_on_q);
  assign rd_sum   = {1'b0, rp_q} + (RPTR_W+1)'(amount_i);

  always_comb begin
    unique case (action_i)
      ACT_WRITE:  room = cur_view.write_room;
      ACT_MIDDLE: room = cur_view.middle_room;
      ACT_POP:    room = cur_view.read_room;
      default:    room = '0;
    endcase
  end

  always_comb begin
    buffer_size_d = buffer_size_q;
    middle_on_d   = middle_on_q;
    wp_d          = wp_q;
    rp_d          = rp_q;
    mp_d          = mp_q;
    status        = STAT_OK;

    if (action_i == ACT_WRITE || action_i == ACT_MIDDLE || action_i == ACT_POP) begin
      if (amount_i == '0) begin
        status = STAT_ZERO;
      end else if (amount_i > room) begin
        status = STAT_OVER;
      end
    end

    if (exec_i && status == STAT_OK) begin
      unique case (action_i)
        ACT_WRITE:  wp_d = wp_q + WPTR_W'(amount_i);
        ACT_MIDDLE: mp_d = mp_q + MPTR_W'(amount_i);
        ACT_POP: begin
          if (rd_sum >= (RPTR_W+1)'(size_eff)) begin
            rp_d = '0;
            wp_d = drop_size(wp_q, size_eff);
            if (middle_on_q) begin
              mp_d = drop_size(mp_q, size_eff);
            end
          end else begin
            rp_d = rd_sum[RPTR_W-1:0];
          end
        end
        ACT_RESET: begin
          wp_d = '0;
          rp_d = '0;
          mp_d = '0;
        end
        default: ;
      endcase
    end

    // The user must write configuration only while no item is in flight; the block itself does not enforce it.
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BUFFER_SIZE: buffer_size_d = cfg_data_i[SIZE_W-1:0];
        CFG_MIDDLE_ON: begin
          middle_on_d = cfg_data_i[0];
          mp_d        = MPTR_W'(rp_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= MAX_SIZE;
      middle_on_q   <= 1'b0;
      wp_q          <= '0;
      rp_q          <= '0;
      mp_q          <= '0;
    end else begin
      buffer_size_q <= buffer_size_d;
      middle_on_q   <= middle_on_d;
      wp_q          <= wp_d;
      rp_q          <= rp_d;
      mp_q          <= mp_d;
    end
  end

  // The reported view is taken after the item has been applied.
  assign result_o.status = status;
  assign result_o.view   = make_view(wp_d, rp_d, mp_d, size_eff, middle_on_q);

  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && action_i == ACT_RESET |=> wp_q == '0 && rp_q == '0 && mp_q == '0)
    else $error("pointer reset did not clear the pointers");

  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && status != STAT_OK |=> $stable(wp_q) && $stable(rp_q) && $stable(mp_q))
    else $error("refused commit changed a pointer");

  a_middle_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_i && !middle_on_q |-> result_o.view.middle_room == '0
                              && result_o.view.middle_offset == '0)
    else $error("middle stage reports room while disabled");

endmodule

`default_nettype wire

FILE: design/rbc_out_reg.sv
`default_nettype none

module rbc_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire rbc_pkg::rbc_result_t result_i,
  output logic                      can_load_o,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output rbc_pkg::rbc_result_t      result_o
);
  import rbc_pkg::*;

  logic        valid_q, valid_d;
  rbc_result_t data_q;

  // A new beat may load in the same cycle the held one is taken.
  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !valid_q || ready_i)
    else $error("result register overwritten while a beat was waiting");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not presented");

  a_taken_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && ready_i && !load_i |=> !valid_q)
    else $error("taken result presented again");

endmodule

`default_nettype wire

FILE: bench/three_pointer_ring_buffer_control_top_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
  logic [rbc_pkg::STAT_W-1:0] status;
  logic [rbc_pkg::OFF_W-1:0]  write_offset;
  logic [rbc_pkg::ROOM_W-1:0] write_room;
  logic [rbc_pkg::OFF_W-1:0]  middle_offset;
  logic [rbc_pkg::ROOM_W-1:0] middle_room;
  logic [rbc_pkg::OFF_W-1:0]  read_offset;
  logic [rbc_pkg::ROOM_W-1:0] read_room;
  logic [rbc_pkg::ROOM_W-1:0] fill_length;
} ring_view_t;

class ring_scoreboard;
  bit [rbc_pkg::SIZE_W-1:0] size_cfg;
  bit                       stage_on;
  longint                   wr_ptr;
  longint                   rd_ptr;
  longint                   mid_ptr;
  ring_view_t               expected_q[$];
  int                       errors;

  function new();
    size_cfg = rbc_pkg::MAX_SIZE;
    stage_on = 1'b0;
    wr_ptr   = 0;
    rd_ptr   = 0;
    mid_ptr  = 0;
    errors   = 0;
  endfunction

  function longint ring_size();
    longint s;
    s = longint'(size_cfg);
    if (s < 1) s = 1;
    if (s > rbc_pkg::MAX_BYTES) s = rbc_pkg::MAX_BYTES;
    return s;
  endfunction

  function longint clip(longint v);
    return (v < 0) ? 0 : v;
  endfunction

  function longint write_room();
    longint s;
    s = ring_size();
    return clip((wr_ptr >= s) ? s + rd_ptr - wr_ptr : s - wr_ptr);
  endfunction

  function longint middle_room();
    longint s;
    s = ring_size();
    if (!stage_on) return 0;
    return clip((mid_ptr < s && wr_ptr > s) ? s - mid_ptr : wr_ptr - mid_ptr);
  endfunction

  function longint read_room();
    longint s;
    longint lim;
    s   = ring_size();
    lim = stage_on ? mid_ptr : wr_ptr;
    return clip((lim > s) ? s - rd_ptr : lim - rd_ptr);
  endfunction

  function longint offset_in_ring(longint p);
    longint s;
    s = ring_size();
    return (p >= s) ? p - s : p;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void write_register(rbc_pkg::rbc_cfg_e idx, bit [rbc_pkg::CFG_DAT_W-1:0] data);
    if (idx == rbc_pkg::CFG_BUFFER_SIZE) begin
      size_cfg = data;
    end else if (idx == rbc_pkg::CFG_MIDDLE_ON) begin
      stage_on = data[0];
      // Every buffered byte counts as unprocessed again.
      mid_ptr  = rd_ptr;
    end
  endfunction

  function void note_command(bit [rbc_pkg::ACT_W-1:0] action, bit [rbc_pkg::AMT_W-1:0] amount);
    longint     s;
    longint     room;
    longint     amt;
    ring_view_t e;
    s = ring_size();
    amt = longint'(amount);
    e.status = rbc_pkg::STAT_OK;
    if (action == rbc_pkg::ACT_WRITE || action == rbc_pkg::ACT_MIDDLE ||
        action == rbc_pkg::ACT_POP) begin
      if (action == rbc_pkg::ACT_WRITE) room = write_room();
      else if (action == rbc_pkg::ACT_MIDDLE) room = middle_room();
      else room = read_room();
      if (amt == 0) begin
        e.status = rbc_pkg::STAT_ZERO;
      end else if (amt > room) begin
        e.status = rbc_pkg::STAT_OVER;
      end else if (action == rbc_pkg::ACT_WRITE) begin
        wr_ptr = (wr_ptr + amt) & ((longint'(1) << rbc_pkg::WPTR_W) - 1);
      end else if (action == rbc_pkg::ACT_MIDDLE) begin
        mid_ptr = (mid_ptr + amt) & ((longint'(1) << rbc_pkg::MPTR_W) - 1);
      end else if (rd_ptr + amt >= s) begin
        // The read pointer reached the end of the ring: everything slides down.
        rd_ptr = 0;
        wr_ptr = clip(wr_ptr - s);
        if (stage_on) mid_ptr = clip(mid_ptr - s);
      end else begin
        rd_ptr = (rd_ptr + amt) & ((longint'(1) << rbc_pkg::RPTR_W) - 1);
      end
    end else if (action == rbc_pkg::ACT_RESET) begin
      wr_ptr  = 0;
      rd_ptr  = 0;
      mid_ptr = 0;
    end
    e.write_offset  = 16'(offset_in_ring(wr_ptr));
    e.write_room    = 17'(write_room());
    e.middle_offset = stage_on ? 16'(offset_in_ring(mid_ptr)) : 16'd0;
    e.middle_room   = 17'(middle_room());
    e.read_offset   = 16'(rd_ptr);
    e.read_room     = 17'(read_room());
    e.fill_length   = 17'(clip(wr_ptr - rd_ptr));
    expected_q.push_back(e);
  endfunction

  function void compare_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(ring_view_t got);
    ring_view_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: result beat with no command outstanding, expected none, actual %h",
               $time, got);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    compare_field("status", longint'(e.status), longint'(got.status));
    compare_field("write_offset", longint'(e.write_offset), longint'(got.write_offset));
    compare_field("write_room", longint'(e.write_room), longint'(got.write_room));
    compare_field("middle_offset", longint'(e.middle_offset), longint'(got.middle_offset));
    compare_field("middle_room", longint'(e.middle_room), longint'(got.middle_room));
    compare_field("read_offset", longint'(e.read_offset), longint'(got.read_offset));
    compare_field("read_room", longint'(e.read_room), longint'(got.read_room));
    compare_field("fill_length", longint'(e.fill_length), longint'(got.fill_length));
  endfunction
endclass

module three_pointer_ring_buffer_control_top_tb;
  import rbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 300000;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned ITEMS_PER_PHASE = 93;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [ACT_W-1:0]     action_i;
  logic [AMT_W-1:0]     amount_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STAT_W-1:0]    status_o;
  logic [OFF_W-1:0]     write_offset_o;
  logic [ROOM_W-1:0]    write_room_o;
  logic [OFF_W-1:0]     middle_offset_o;
  logic [ROOM_W-1:0]    middle_room_o;
  logic [OFF_W-1:0]     read_offset_o;
  logic [ROOM_W-1:0]    read_room_o;
  logic [ROOM_W-1:0]    fill_length_o;

  ring_scoreboard ring_sb = new();
  bit             no_gaps = 1'b0;
  int unsigned    cycle_count = 0;

  three_pointer_ring_buffer_control_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .amount_i        (amount_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .write_offset_o  (write_offset_o),
    .write_room_o    (write_room_o),
    .middle_offset_o (middle_offset_o),
    .middle_room_o   (middle_room_o),
    .read_offset_o   (read_offset_o),
    .read_room_o     (read_room_o),
    .fill_length_o   (fill_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("three_pointer_ring_buffer_control_top_tb failed");
      $finish;
    end
  end

  task automatic send_command(input logic [ACT_W-1:0] act, input logic [AMT_W-1:0] amt);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    amount_i   <= amt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ring_sb.note_command(act, amt);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ring_sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_cfg(input rbc_cfg_e idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    ring_sb.write_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly commands that fit the current room, so the pointers wrap often.
  task automatic random_command();
    int unsigned      pick;
    int unsigned      room;
    logic [ACT_W-1:0] act;
    logic [AMT_W-1:0] amt;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      act = ACT_W'($urandom_range(0, 7));
      amt = AMT_W'($urandom);
    end else if (pick < 10) begin
      case ($urandom_range(0, 2))
        0:       act = ACT_WRITE;
        1:       act = ACT_MIDDLE;
        default: act = ACT_POP;
      endcase
      amt = '0;
    end else if (pick < 13) begin
      act = ACT_QUERY;
      amt = AMT_W'($urandom);
    end else if (pick < 15) begin
      act = ACT_RESET;
      amt = AMT_W'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0:       act = ACT_WRITE;
        1:       act = ring_sb.stage_on ? ACT_MIDDLE : ACT_WRITE;
        default: act = ACT_POP;
      endcase
      if (act == ACT_WRITE) room = 32'(ring_sb.write_room());
      else if (act == ACT_MIDDLE) room = 32'(ring_sb.middle_room());
      else room = 32'(ring_sb.read_room());
      pick = $urandom_range(0, 99);
      if (room == 0 || pick < 5) amt = AMT_W'(room + 1);
      else if (pick < 25) amt = AMT_W'(room);
      else if (pick < 60) amt = AMT_W'($urandom_range(1, (room < 8) ? room : 8));
      else amt = AMT_W'($urandom_range(1, room));
    end
    send_command(act, amt);
  endtask

  // Result side: random stalls, every beat is checked against the scoreboard.
  initial begin
    int unsigned stall;
    ring_view_t  got;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 13);
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.status        = status_o;
      got.write_offset  = write_offset_o;
      got.write_room    = write_room_o;
      got.middle_offset = middle_offset_o;
      got.middle_room   = middle_room_o;
      got.read_offset   = read_offset_o;
      got.read_room     = read_room_o;
      got.fill_length   = fill_length_o;
      ring_sb.check_result(got);
    end
  end

  initial begin
    int unsigned phase_size [PHASES];
    bit          phase_on   [PHASES];
    phase_size = '{65536, 1, 0, 16, 131071, 100, 0, 0, 5, 65536};
    phase_on   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    phase_size[6] = $urandom_range(2, 300);
    phase_size[7] = $urandom_range(0, 131071);

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_BUFFER_SIZE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    action_i    = ACT_QUERY;
    amount_i    = '0;
    out_ready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full-size ring with the middle stage off: refusals, a full fill and a wrap.
    send_command(ACT_QUERY, '0);
    send_command(ACT_WRITE, '0);
    send_command(ACT_WRITE, 17'd65536);
    send_command(ACT_WRITE, 17'd1);
    send_command(ACT_POP, 17'h1FFFF);
    send_command(ACT_MIDDLE, 17'd5);
    send_command(ACT_MIDDLE, '0);
    send_command(ACT_POP, 17'd65536);
    send_command(3'd5, 17'h1FFFF);
    send_command(ACT_WRITE, 17'd40000);
    send_command(3'd6, 17'd3);
    send_command(ACT_RESET, 17'd7);
    send_command(3'd7, 17'd1);
    send_command(ACT_POP, '0);
    drain();

    // Small ring with the middle stage on: the write pointer runs past the size.
    write_cfg(CFG_BUFFER_SIZE, 17'd16);
    write_cfg(CFG_MIDDLE_ON, 17'h1FFFF);
    send_command(ACT_WRITE, 17'd12);
    send_command(ACT_MIDDLE, 17'd5);
    send_command(ACT_POP, 17'd3);
    send_command(ACT_POP, 17'd3);
    send_command(ACT_MIDDLE, 17'd7);
    send_command(ACT_WRITE, 17'd7);
    send_command(ACT_WRITE, 17'd4);
    send_command(ACT_WRITE, 17'd3);
    send_command(ACT_MIDDLE, 17'd4);
    send_command(ACT_POP, 17'd13);
    send_command(ACT_QUERY, '0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_cfg(CFG_BUFFER_SIZE, CFG_DAT_W'(phase_size[p]));
      write_cfg(CFG_MIDDLE_ON, {16'($urandom), phase_on[p]});
      no_gaps = (p == 3 || p == 7);
      repeat (ITEMS_PER_PHASE) random_command();
      drain();
    end

    no_gaps = 1'b0;
    repeat (8) @(posedge clk_i);
    if (ring_sb.errors == 0 && ring_sb.pending() == 0) begin
      $display("three_pointer_ring_buffer_control_top_tb passed");
    end else begin
      $display("three_pointer_ring_buffer_control_top_tb failed");
    end
    $finish;
  end

endmodule
